FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define VAD_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication
`define VAD_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

FILE: hdl/vad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_pkg
// Shared constants and the CORDIC arc tangent table.
// ----------------------------------------------------------------------------
package vad_pkg;

    localparam int COMPONENT_WIDTH_DEF     = 16;
    localparam int ANGLE_FRACTION_BITS_DEF = 8;
    localparam int FIELD_W                 = 16;
    localparam int OUT_W                   = 16;

    // Operands are normalized below 2^NORM_W before the root and CORDIC
    localparam int NORM_W       = 30;
    localparam int SQ_W         = 2 * NORM_W + 2;
    localparam int SQRT_W       = NORM_W + 1;
    localparam int SQRT_STEPS   = SQRT_W;
    localparam int ACC_FRAC     = 24;
    localparam int CORDIC_STEPS = 24;
    localparam int XW           = NORM_W + 6;
    localparam int ZW           = 34;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic signed [ZW-1:0] atan_deg(input int idx);
        logic signed [ZW-1:0] v;
        begin
            case (idx)
                0:       v = ZW'(754974720);
                1:       v = ZW'(445687602);
                2:       v = ZW'(235489088);
                3:       v = ZW'(119537938);
                4:       v = ZW'(60000934);
                5:       v = ZW'(30029717);
                6:       v = ZW'(15018523);
                7:       v = ZW'(7509720);
                8:       v = ZW'(3754917);
                9:       v = ZW'(1877466);
                10:      v = ZW'(938734);
                11:      v = ZW'(469367);
                12:      v = ZW'(234684);
                13:      v = ZW'(117342);
                14:      v = ZW'(58671);
                15:      v = ZW'(29335);
                16:      v = ZW'(14668);
                17:      v = ZW'(7334);
                18:      v = ZW'(3667);
                19:      v = ZW'(1833);
                20:      v = ZW'(917);
                21:      v = ZW'(458);
                22:      v = ZW'(229);
                23:      v = ZW'(115);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: hdl/vad_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_lane
// One axis lane: dot product term and magnitude of one cross component.
// ----------------------------------------------------------------------------
module vad_lane
    import vad_pkg::*;
#(
    parameter int CW = COMPONENT_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [CW-1:0]  a_self,
    input  logic signed [CW-1:0]  b_self,
    input  logic signed [CW-1:0]  a_p,
    input  logic signed [CW-1:0]  b_q,
    input  logic signed [CW-1:0]  a_q,
    input  logic signed [CW-1:0]  b_p,
    output logic signed [2*CW-1:0] dot_term,
    output logic [2*CW:0]          cross_mag
);

    logic signed [2*CW-1:0] dot_reg;
    logic signed [2*CW-1:0] pq_reg;
    logic signed [2*CW-1:0] qp_reg;
    logic signed [2*CW-1:0] term_reg;
    logic [2*CW:0]          mag_reg;
    logic signed [2*CW:0]   diff;
    logic [2*CW:0]          mag_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot_reg  <= a_self * b_self;
            pq_reg   <= a_p * b_q;
            qp_reg   <= a_q * b_p;
            term_reg <= dot_reg;
            mag_reg  <= mag_next;
        end
    end

    always_comb
    begin
        diff = $signed({pq_reg[2*CW-1], pq_reg}) - $signed({qp_reg[2*CW-1], qp_reg});
        mag_next = diff[2*CW] ? $unsigned(-diff) : $unsigned(diff);
    end

    assign dot_term  = term_reg;
    assign cross_mag = mag_reg;

endmodule

FILE: hdl/vad_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_sqrt
// Pipelined integer square root, one result bit per stage, with a side tag.
// ----------------------------------------------------------------------------
module vad_sqrt
    import vad_pkg::*;
#(
    parameter int TAG_W = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [SQ_W-1:0]   radicand,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_vld,
    output logic [SQRT_W-1:0] root,
    output logic [TAG_W-1:0]  out_tag
);

    localparam int RW = SQ_W + 1;

    logic [SQ_W-1:0]  rem_reg [SQRT_STEPS];
    logic [RW-1:0]    r_reg   [SQRT_STEPS];
    logic [TAG_W-1:0] tag_reg [SQRT_STEPS];
    logic             v_reg   [SQRT_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++)
        begin : g_step
            localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQRT_STEPS - 1 - k));
            logic [SQ_W-1:0]  rem_in;
            logic [RW-1:0]    r_in;
            logic [TAG_W-1:0] tag_in;
            logic             v_in;
            logic [RW-1:0]    trial;
            logic [SQ_W-1:0]  rem_next;
            logic [RW-1:0]    r_next;

            if (k == 0)
            begin : g_first
                assign rem_in = radicand;
                assign r_in   = '0;
                assign tag_in = in_tag;
                assign v_in   = in_vld;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign r_in   = r_reg[k-1];
                assign tag_in = tag_reg[k-1];
                assign v_in   = v_reg[k-1];
            end

            always_comb
            begin
                trial = r_in + BIT;
                if ({1'b0, rem_in} >= trial)
                begin
                    rem_next = rem_in - trial[SQ_W-1:0];
                    r_next   = (r_in >> 1) + BIT;
                end
                else
                begin
                    rem_next = rem_in;
                    r_next   = r_in >> 1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    r_reg[k]   <= r_next;
                    tag_reg[k] <= tag_in;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (en)
                    v_reg[k] <= v_in;
            end
        end
    endgenerate

    assign out_vld = v_reg[SQRT_STEPS-1];
    assign root    = r_reg[SQRT_STEPS-1][SQRT_W-1:0];
    assign out_tag = tag_reg[SQRT_STEPS-1];

endmodule

FILE: hdl/vad_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_cordic
// Pipelined CORDIC vectoring: atan(y/x) in degrees, one iteration per stage.
// ----------------------------------------------------------------------------
module vad_cordic
    import vad_pkg::*;
#(
    parameter int TAG_W = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic [TAG_W-1:0]     in_tag,
    output logic                 out_vld,
    output logic signed [ZW-1:0] z_out,
    output logic [TAG_W-1:0]     out_tag
);

    logic signed [XW-1:0] x_reg   [CORDIC_STEPS];
    logic signed [XW-1:0] y_reg   [CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg   [CORDIC_STEPS];
    logic [TAG_W-1:0]     tag_reg [CORDIC_STEPS];
    logic                 v_reg   [CORDIC_STEPS];

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_iter
            localparam logic signed [ZW-1:0] ANG = atan_deg(i);
            logic signed [XW-1:0] xi;
            logic signed [XW-1:0] yi;
            logic signed [ZW-1:0] zi;
            logic [TAG_W-1:0]     ti;
            logic                 vi;
            logic signed [XW-1:0] xs;
            logic signed [XW-1:0] ys;

            if (i == 0)
            begin : g_first
                assign xi = x_in;
                assign yi = y_in;
                assign zi = '0;
                assign ti = in_tag;
                assign vi = in_vld;
            end
            else
            begin : g_rest
                assign xi = x_reg[i-1];
                assign yi = y_reg[i-1];
                assign zi = z_reg[i-1];
                assign ti = tag_reg[i-1];
                assign vi = v_reg[i-1];
            end

            assign xs = xi >>> i;
            assign ys = yi >>> i;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    // rotate toward the x axis
                    if (yi > 0)
                    begin
                        x_reg[i] <= xi + ys;
                        y_reg[i] <= yi - xs;
                        z_reg[i] <= zi + ANG;
                    end
                    else
                    begin
                        x_reg[i] <= xi - ys;
                        y_reg[i] <= yi + xs;
                        z_reg[i] <= zi - ANG;
                    end
                    tag_reg[i] <= ti;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else if (en)
                    v_reg[i] <= vi;
            end
        end
    endgenerate

    assign out_vld = v_reg[CORDIC_STEPS-1];
    assign z_out   = z_reg[CORDIC_STEPS-1];
    assign out_tag = tag_reg[CORDIC_STEPS-1];

endmodule

FILE: hdl/vector_angle_degrees.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_angle_degrees
// Angle between two signed 3-axis vectors, degrees in unsigned fixed point.
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless stalled and returns one result per
// transaction: 8 front stages (three axis lanes multiply, then dot sum,
// magnitude, leading-bit search, normalizing shift, squares, sum), 31
// square-root stages, 24 CORDIC stages and the output register. All stages
// advance together; in_stall rises only while a finished result waits in the
// output register. A zero-length vector returns angle 0 with angle_invalid.
module vector_angle_degrees
    import vad_pkg::*;
#(
    parameter int COMPONENT_WIDTH     = COMPONENT_WIDTH_DEF,
    parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [FIELD_W-1:0] first_x,
    input  logic signed [FIELD_W-1:0] first_y,
    input  logic signed [FIELD_W-1:0] first_z,
    input  logic signed [FIELD_W-1:0] second_x,
    input  logic signed [FIELD_W-1:0] second_y,
    input  logic signed [FIELD_W-1:0] second_z,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [OUT_W-1:0]          angle_deg,
    output logic                      angle_invalid
);

`include "assert_macros.svh"

    localparam int CW   = COMPONENT_WIDTH;
    localparam int PW   = 2 * CW;
    localparam int MW   = 2 * CW + 2;
    localparam int BL_W = $clog2(MW + 1);
    localparam int SH   = ACC_FRAC - ANGLE_FRACTION_BITS;
    localparam int UW   = ZW - 1;
    localparam logic [UW-1:0] DEG90  = UW'(90) << ACC_FRAC;
    localparam logic [UW-1:0] DEG180 = UW'(180) << ACC_FRAC;
    localparam logic [UW-1:0] HALF   = UW'(1) << (SH - 1);
    localparam logic [UW-1:0] OUT_MAX = UW'({OUT_W{1'b1}});
    localparam logic [UW-1:0] TOP_RAW = UW'(180) << ANGLE_FRACTION_BITS;
    localparam logic [OUT_W-1:0] TOP_OUT = (TOP_RAW > OUT_MAX) ?
        {OUT_W{1'b1}} : TOP_RAW[OUT_W-1:0];

    logic en;
    logic out_valid_reg;
    logic signed [CW-1:0] ax, ay, az, bx, by, bz;
    logic in_zero;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    generate
        if (CW <= FIELD_W)
        begin : g_narrow
            assign ax = first_x[CW-1:0];
            assign ay = first_y[CW-1:0];
            assign az = first_z[CW-1:0];
            assign bx = second_x[CW-1:0];
            assign by = second_y[CW-1:0];
            assign bz = second_z[CW-1:0];
        end
        else
        begin : g_wide
            // upper bits above the field are zero
            assign ax = {{(CW-FIELD_W){1'b0}}, first_x};
            assign ay = {{(CW-FIELD_W){1'b0}}, first_y};
            assign az = {{(CW-FIELD_W){1'b0}}, first_z};
            assign bx = {{(CW-FIELD_W){1'b0}}, second_x};
            assign by = {{(CW-FIELD_W){1'b0}}, second_y};
            assign bz = {{(CW-FIELD_W){1'b0}}, second_z};
        end
    endgenerate

    assign in_zero = (ax == '0 && ay == '0 && az == '0) ||
                     (bx == '0 && by == '0 && bz == '0);

    // ---------------- axis lanes ----------------
    logic signed [PW-1:0] term_x, term_y, term_z;
    logic [PW:0]          cmag_x, cmag_y, cmag_z;

    vad_lane #(.CW(CW)) u_lane_x
    (
        .clk(clk), .en(en),
        .a_self(ax), .b_self(bx), .a_p(ay), .b_q(bz), .a_q(az), .b_p(by),
        .dot_term(term_x), .cross_mag(cmag_x)
    );

    vad_lane #(.CW(CW)) u_lane_y
    (
        .clk(clk), .en(en),
        .a_self(ay), .b_self(by), .a_p(az), .b_q(bx), .a_q(ax), .b_p(bz),
        .dot_term(term_y), .cross_mag(cmag_y)
    );

    vad_lane #(.CW(CW)) u_lane_z
    (
        .clk(clk), .en(en),
        .a_self(az), .b_self(bz), .a_p(ax), .b_q(by), .a_q(ay), .b_p(bx),
        .dot_term(term_z), .cross_mag(cmag_z)
    );

    // ---------------- merge and normalize ----------------
    logic [7:0] v_reg;
    logic [7:0] inv_reg;

    logic signed [MW-1:0] dot_reg;
    logic [MW-1:0] c1_reg, c2_reg, c3_reg;
    logic [MW-1:0] ud_d_reg, c1_d_reg, c2_d_reg, c3_d_reg;
    logic          neg_d_reg;
    logic [MW-1:0] ud_e_reg, c1_e_reg, c2_e_reg, c3_e_reg;
    logic          neg_e_reg;
    logic [BL_W-1:0] s_e_reg;
    logic [NORM_W-1:0] ud_f_reg, c1_f_reg, c2_f_reg, c3_f_reg;
    logic              neg_f_reg;
    logic [NORM_W-1:0] ud_g_reg;
    logic [2*NORM_W-1:0] q1_reg, q2_reg, q3_reg;
    logic                neg_g_reg;
    logic [NORM_W-1:0] ud_h_reg;
    logic [SQ_W-1:0]   sum_h_reg;
    logic              neg_h_reg;

    logic signed [MW-1:0] dot_next;
    logic [MW-1:0]        or_all;
    logic [BL_W-1:0]      blen;
    logic [BL_W-1:0]      s_next;

    always_comb
    begin
        dot_next = MW'(term_x) + MW'(term_y) + MW'(term_z);
        or_all   = ud_d_reg | c1_d_reg | c2_d_reg | c3_d_reg;
        blen     = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (or_all[i])
                blen = BL_W'(i + 1);
        end
        s_next = (blen > BL_W'(NORM_W)) ? blen - BL_W'(NORM_W) : '0;
    end

    function automatic logic [NORM_W-1:0] norm_shift(input logic [MW-1:0] v,
                                                     input logic [BL_W-1:0] s);
        logic [MW+NORM_W-1:0] w;
        begin
            w = {{NORM_W{1'b0}}, v} >> s;
            return w[NORM_W-1:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot_reg   <= dot_next;
            c1_reg    <= MW'(cmag_x);
            c2_reg    <= MW'(cmag_y);
            c3_reg    <= MW'(cmag_z);

            ud_d_reg  <= dot_reg[MW-1] ? $unsigned(-dot_reg) : $unsigned(dot_reg);
            neg_d_reg <= dot_reg[MW-1];
            c1_d_reg  <= c1_reg;
            c2_d_reg  <= c2_reg;
            c3_d_reg  <= c3_reg;

            s_e_reg   <= s_next;
            ud_e_reg  <= ud_d_reg;
            c1_e_reg  <= c1_d_reg;
            c2_e_reg  <= c2_d_reg;
            c3_e_reg  <= c3_d_reg;
            neg_e_reg <= neg_d_reg;

            ud_f_reg  <= norm_shift(ud_e_reg, s_e_reg);
            c1_f_reg  <= norm_shift(c1_e_reg, s_e_reg);
            c2_f_reg  <= norm_shift(c2_e_reg, s_e_reg);
            c3_f_reg  <= norm_shift(c3_e_reg, s_e_reg);
            neg_f_reg <= neg_e_reg;

            q1_reg    <= c1_f_reg * c1_f_reg;
            q2_reg    <= c2_f_reg * c2_f_reg;
            q3_reg    <= c3_f_reg * c3_f_reg;
            ud_g_reg  <= ud_f_reg;
            neg_g_reg <= neg_f_reg;

            sum_h_reg <= SQ_W'(q1_reg) + SQ_W'(q2_reg) + SQ_W'(q3_reg);
            ud_h_reg  <= ud_g_reg;
            neg_h_reg <= neg_g_reg;
        end
    end

    // valid and invalid-flag tracking for the lane and merge stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            inv_reg <= '0;
        end
        else if (en)
        begin
            v_reg   <= {v_reg[6:0], in_valid};
            inv_reg <= {inv_reg[6:0], in_zero};
        end
    end

    // ---------------- square root ----------------
    localparam int STAG_W = NORM_W + 2;
    logic              sq_vld;
    logic [SQRT_W-1:0] sq_root;
    logic [STAG_W-1:0] sq_tag;

    vad_sqrt #(.TAG_W(STAG_W)) u_sqrt
    (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(v_reg[7]),
        .radicand(sum_h_reg),
        .in_tag({ud_h_reg, neg_h_reg, inv_reg[7]}),
        .out_vld(sq_vld), .root(sq_root), .out_tag(sq_tag)
    );

    // ---------------- CORDIC ----------------
    logic                 co_vld;
    logic signed [ZW-1:0] co_z;
    logic [1:0]           co_tag;
    logic signed [XW-1:0] cx_in, cy_in;

    assign cx_in = {{(XW-NORM_W){1'b0}}, sq_tag[STAG_W-1:2]};
    assign cy_in = {{(XW-SQRT_W){1'b0}}, sq_root};

    vad_cordic #(.TAG_W(2)) u_cordic
    (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(sq_vld), .x_in(cx_in), .y_in(cy_in), .in_tag(sq_tag[1:0]),
        .out_vld(co_vld), .z_out(co_z), .out_tag(co_tag)
    );

    // ---------------- clamp, fold, round ----------------
    logic [UW-1:0]    z_clamp, z_fold, z_round;
    logic [OUT_W-1:0] angle_next;

    always_comb
    begin
        if (co_z[ZW-1])
            z_clamp = '0;
        else if (co_z[UW-1:0] > DEG90)
            z_clamp = DEG90;
        else
            z_clamp = co_z[UW-1:0];
        z_fold  = co_tag[1] ? DEG180 - z_clamp : z_clamp;
        z_round = (z_fold + HALF) >> SH;
        if (co_tag[0])
            angle_next = '0;
        else if (z_round > OUT_MAX)
            angle_next = {OUT_W{1'b1}};
        else
            angle_next = z_round[OUT_W-1:0];
    end

    logic [OUT_W-1:0] angle_reg;
    logic             invalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= co_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg   <= angle_next;
            invalid_reg <= co_tag[0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign angle_deg     = angle_reg;
    assign angle_invalid = invalid_reg;

    // ---------------- assertions ----------------
    `VAD_ASSERT_NOW(a_invalid_zero, clk, rst_n,
        out_valid && angle_invalid, angle_deg == '0)
    `VAD_ASSERT_NOW(a_angle_range, clk, rst_n,
        out_valid && !angle_invalid, angle_deg <= TOP_OUT)
    `VAD_ASSERT_NEXT(a_accept_enters, clk, rst_n,
        in_valid && !in_stall, v_reg[0])

endmodule
